FILE: rtl/core/egcd_pkg.sv
// ----------------------------------------------------------------------------
// Extended GCD package
// Operand and coefficient widths shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package egcd_pkg;

  // Operands, gcd and inverse are non-negative 31-bit values
  localparam int unsigned OpndW = 31;
  // Bezout coefficients, two's complement
  localparam int unsigned CoefW = 32;
  // Width of the divider's quotient bit counter
  localparam int unsigned CntW  = $clog2(OpndW);

endpackage

FILE: rtl/core/egcd_if.sv
// ----------------------------------------------------------------------------
// Extended GCD channel interfaces
// Valid/ready request and response channels of the extended GCD unit.
// ----------------------------------------------------------------------------
interface egcd_req_if import egcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpndW-1:0] operand_a;
  logic [OpndW-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_rsp_if import egcd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpndW-1:0]        gcd_value;
  logic signed [CoefW-1:0] coeff_a;
  logic signed [CoefW-1:0] coeff_b;
  logic                    inverse_exists;
  logic [OpndW-1:0]        inverse_value;

  modport source (output valid, output gcd_value, output coeff_a, output coeff_b,
                  output inverse_exists, output inverse_value, input ready);
  modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b,
                  input inverse_exists, input inverse_value, output ready);
endinterface

FILE: rtl/core/extended_gcd_mod_inverse_unit.sv
// ----------------------------------------------------------------------------
// Extended GCD and modular inverse unit
// Runs the extended Euclidean algorithm on (a, b) with one shared radix-2
// divider and returns gcd, Bezout coefficients and the inverse of a mod b.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req_i    in   valid / ready  operand_a, operand_b
//  rsp_o    out  valid / ready  gcd_value, coeff_a, coeff_b,
//                               inverse_exists, inverse_value
//
//  Each Euclid step is a restoring-divide pass, one update and one loop check.
//  req_i.ready is high only while the core is idle; the result sits in an
//  output register, so a new request is taken while it waits. A stalled
//  response holds the core in its last state. Reset is asynchronous, active
//  low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module extended_gcd_mod_inverse_unit import egcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  egcd_req_if.sink  req_i,
  egcd_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    StIdle,
    StLoop,
    StDiv,
    StUpd,
    StFixNeg,
    StDone
  } state_e;

  state_e state_q;

  // Euclid pairs
  logic [OpndW-1:0] r0_q, r1_q, b_q;
  logic [CoefW-1:0] s0_q, s1_q, t0_q, t1_q;
  // Divider: partial remainder, shifting dividend, bit count
  logic [OpndW-1:0] p_q, dvd_q;
  logic [CntW-1:0]  cnt_q;
  // q*s1 and q*t1 built bit by bit, MSB first
  logic [CoefW-1:0] acc_s_q, acc_t_q;
  logic [CoefW-1:0] inv_q;

  // Output register
  logic                    out_valid_q;
  logic [OpndW-1:0]        out_gcd_q;
  logic [CoefW-1:0]        out_ca_q, out_cb_q;
  logic                    out_exists_q;
  logic [OpndW-1:0]        out_inv_q;

  logic [OpndW:0]   p_shift;
  logic             q_bit;
  logic [OpndW-1:0] p_d;
  logic [CoefW-1:0] acc_s_d, acc_t_d;
  logic [CoefW-1:0] b_ext;
  logic             exists;
  logic [OpndW-1:0] inv_final;
  logic             out_free;
  logic             div_last;

  // Shared divide step: shift in next dividend bit, compare and subtract
  assign p_shift = {p_q, dvd_q[OpndW-1]};
  assign q_bit   = (p_shift >= {1'b0, r1_q});
  assign p_d     = q_bit ? OpndW'(p_shift - {1'b0, r1_q}) : OpndW'(p_shift);
  assign acc_s_d = {acc_s_q[CoefW-2:0], 1'b0} + (q_bit ? s1_q : '0);
  assign acc_t_d = {acc_t_q[CoefW-2:0], 1'b0} + (q_bit ? t1_q : '0);
  assign div_last = (cnt_q == CntW'(OpndW - 1));

  assign b_ext  = {1'b0, b_q};
  assign exists = (r0_q == OpndW'(1));

  always_comb begin
    inv_final = '0;
    if (exists) begin
      if (b_q != '0 && inv_q >= b_ext) begin
        inv_final = OpndW'(inv_q - b_ext);
      end else begin
        inv_final = inv_q[OpndW-1:0];
      end
    end
  end

  assign out_free = !out_valid_q || rsp_o.ready;

  // Control and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      out_valid_q  <= 1'b0;
      out_gcd_q    <= '0;
      out_ca_q     <= '0;
      out_cb_q     <= '0;
      out_exists_q <= 1'b0;
      out_inv_q    <= '0;
    end else begin
      if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            state_q <= StLoop;
          end
        end
        StLoop: begin
          state_q <= (r1_q == '0) ? StFixNeg : StDiv;
        end
        StDiv: begin
          if (div_last) begin
            state_q <= StUpd;
          end
        end
        StUpd: begin
          state_q <= StLoop;
        end
        StFixNeg: begin
          state_q <= StDone;
        end
        StDone: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_gcd_q    <= r0_q;
            out_ca_q     <= s0_q;
            out_cb_q     <= t0_q;
            out_exists_q <= exists;
            out_inv_q    <= inv_final;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          r0_q <= req_i.operand_a;
          r1_q <= req_i.operand_b;
          b_q  <= req_i.operand_b;
          s0_q <= CoefW'(1);
          s1_q <= '0;
          t0_q <= '0;
          t1_q <= CoefW'(1);
        end
      end
      StLoop: begin
        p_q     <= '0;
        dvd_q   <= r0_q;
        cnt_q   <= '0;
        acc_s_q <= '0;
        acc_t_q <= '0;
      end
      StDiv: begin
        p_q     <= p_d;
        dvd_q   <= {dvd_q[OpndW-2:0], 1'b0};
        cnt_q   <= cnt_q + CntW'(1);
        acc_s_q <= acc_s_d;
        acc_t_q <= acc_t_d;
      end
      StUpd: begin
        r0_q <= r1_q;
        r1_q <= p_q;
        s0_q <= s1_q;
        s1_q <= s0_q - acc_s_q;
        t0_q <= t1_q;
        t1_q <= t0_q - acc_t_q;
      end
      StFixNeg: begin
        // fold a negative coefficient into the residue range
        inv_q <= (s0_q[CoefW-1] && b_q != '0) ? s0_q + b_ext : s0_q;
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready          = (state_q == StIdle);
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.gcd_value      = out_gcd_q;
  assign rsp_o.coeff_a        = out_ca_q;
  assign rsp_o.coeff_b        = out_cb_q;
  assign rsp_o.inverse_exists = out_exists_q;
  assign rsp_o.inverse_value  = out_inv_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> p_q < r1_q)
    else $error("partial remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv || state_q == StUpd) |-> r1_q != '0)
    else $error("divide pass with zero divisor");

  a_no_inverse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_exists_q |-> out_inv_q == '0)
    else $error("inverse value set without inverse");

  a_div_leaves_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv && div_last |=> state_q == StUpd)
    else $error("division pass did not end in update");
`endif

endmodule
